FILE: rtl/xy_point_to_pixel_mapper_assert.svh
// Assertion macros for the point-to-pixel mapper.
`ifndef XY_POINT_TO_PIXEL_MAPPER_ASSERT_SVH
`define XY_POINT_TO_PIXEL_MAPPER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XYPPM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define XYPPM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/xyppm_pkg.sv
// Shared constants and types of the point-to-pixel mapper.
package xyppm_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int FIELD_BITS  = 32;
  localparam int SCALE_SHIFT = 7;
  localparam int QUO_W       = SCALE_SHIFT;
  localparam int NUM_W       = SAMPLE_BITS + SCALE_SHIFT;
  localparam int INDEX_W     = 8;

  localparam logic [7:0] ROW_OFFSET = 8'd32;

  localparam logic [FIELD_BITS-1:0] RESET_X_LOW  = 32'd0;
  localparam logic [FIELD_BITS-1:0] RESET_X_HIGH = 32'd128;
  localparam logic [FIELD_BITS-1:0] RESET_Y_LOW  = 32'd0;
  localparam logic [FIELD_BITS-1:0] RESET_Y_HIGH = 32'd128;

  typedef enum logic [INDEX_W-1:0] {
    REG_X_LOW  = 8'd0,
    REG_X_HIGH = 8'd1,
    REG_Y_LOW  = 8'd2,
    REG_Y_HIGH = 8'd3
  } reg_index_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] x_low;
    logic [FIELD_BITS-1:0] x_high;
    logic [FIELD_BITS-1:0] y_low;
    logic [FIELD_BITS-1:0] y_high;
  } window_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem_x;
    logic [NUM_W-1:0] div_x;
    logic [NUM_W-1:0] rem_y;
    logic [NUM_W-1:0] div_y;
    logic [QUO_W-1:0] quo_x;
    logic [QUO_W-1:0] quo_y;
    logic             hit;
    logic             last;
  } lane_t;

endpackage

FILE: rtl/xyppm_point_if.sv
// Input channel carrying one data point per transfer.
interface xyppm_point_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [xyppm_pkg::FIELD_BITS-1:0] point_x;
  logic signed [xyppm_pkg::FIELD_BITS-1:0] point_y;
  logic                                 last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input last_point,
                output ready);
endinterface

FILE: rtl/xyppm_result_if.sv
// Output channel carrying one pixel result per transfer.
interface xyppm_result_if;
  logic       valid;
  logic       ready;
  logic       in_window;
  logic [6:0] pixel_column;
  logic [7:0] pixel_row;
  logic       last_result;

  modport source (output valid, output in_window, output pixel_column,
                  output pixel_row, output last_result, input ready);
  modport sink (input valid, input in_window, input pixel_column,
                input pixel_row, input last_result, output ready);
endinterface

FILE: rtl/xyppm_cfg_if.sv
// Register write channel.
interface xyppm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [xyppm_pkg::INDEX_W-1:0]     index;
  logic [xyppm_pkg::FIELD_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/xy_point_to_pixel_mapper.sv
// Point-to-pixel mapper top level: window registers, front stage and division chain.
// The pipeline is 1 front stage followed by 7 division cells.
// Throughput: one point per cycle; each cell resolves one quotient bit of both axes.
// A stalled output holds the chain; each stage refills as soon as its successor moves.
// Reset (rst, synchronous) empties the pipeline and sets the window to x, y in [0, 128).
module xy_point_to_pixel_mapper (
  input  logic            clk,
  input  logic            rst,
  xyppm_point_if.sink     point,
  xyppm_result_if.source  result,
  xyppm_cfg_if.sink       cfg
);
  localparam int QW = xyppm_pkg::QUO_W;

  xyppm_pkg::window_t window;
  xyppm_pkg::lane_t   lanes  [QW+1];
  logic [QW:0]        valids;
  logic [QW:0]        readies;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window.x_low  <= xyppm_pkg::RESET_X_LOW;
      window.x_high <= xyppm_pkg::RESET_X_HIGH;
      window.y_low  <= xyppm_pkg::RESET_Y_LOW;
      window.y_high <= xyppm_pkg::RESET_Y_HIGH;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        xyppm_pkg::REG_X_LOW:  window.x_low  <= cfg.data;
        xyppm_pkg::REG_X_HIGH: window.x_high <= cfg.data;
        xyppm_pkg::REG_Y_LOW:  window.y_low  <= cfg.data;
        xyppm_pkg::REG_Y_HIGH: window.y_high <= cfg.data;
        default: ;
      endcase
    end
  end

  xyppm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .point     (point),
    .window    (window),
    .out_valid (valids[0]),
    .out_ready (readies[0]),
    .out_lane  (lanes[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    xyppm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valids[i]),
      .in_ready  (readies[i]),
      .in_lane   (lanes[i]),
      .out_valid (valids[i+1]),
      .out_ready (readies[i+1]),
      .out_lane  (lanes[i+1])
    );
  end

  assign readies[QW]         = result.ready;
  assign result.valid        = valids[QW];
  assign result.in_window    = lanes[QW].hit;
  assign result.last_result  = lanes[QW].last;
  assign result.pixel_column = lanes[QW].hit ? lanes[QW].quo_x : '0;
  assign result.pixel_row    = lanes[QW].hit
                               ? (xyppm_pkg::ROW_OFFSET + {1'b0, lanes[QW].quo_y}) : '0;

`include "xy_point_to_pixel_mapper_assert.svh"

  `XYPPM_ASSERT_SAME(a_outside_zero, clk, rst, result.valid && !result.in_window,
    result.pixel_column == 7'd0 && result.pixel_row == 8'd0, "outside point with nonzero pixel")
  `XYPPM_ASSERT_SAME(a_inside_range, clk, rst, result.valid && result.in_window,
    result.pixel_column <= 7'd126 && result.pixel_row >= 8'd32 && result.pixel_row <= 8'd159,
    "inside pixel out of range")
  `XYPPM_ASSERT_NEXT(a_front_load, clk, rst, point.valid && point.ready, valids[0],
    "accepted point not held by front stage")
endmodule

FILE: rtl/xyppm_front.sv
// Front stage: window test, offsets and scaled numerators.
module xyppm_front (
  input  logic               clk,
  input  logic               rst,
  xyppm_point_if.sink        point,
  input  xyppm_pkg::window_t window,
  output logic               out_valid,
  input  logic               out_ready,
  output xyppm_pkg::lane_t   out_lane
);
  localparam int SB = xyppm_pkg::SAMPLE_BITS;
  localparam int NW = xyppm_pkg::NUM_W;

  logic signed [SB:0] px, py, xl, xh, yl, yh;
  logic signed [SB:0] dx, dy, wx, wy;
  logic [NW-1:0]      dxe, dye;
  xyppm_pkg::lane_t   lane_next;

  assign px = {point.point_x[SB-1], point.point_x[SB-1:0]};
  assign py = {point.point_y[SB-1], point.point_y[SB-1:0]};
  assign xl = {window.x_low[SB-1], window.x_low[SB-1:0]};
  assign xh = {window.x_high[SB-1], window.x_high[SB-1:0]};
  assign yl = {window.y_low[SB-1], window.y_low[SB-1:0]};
  assign yh = {window.y_high[SB-1], window.y_high[SB-1:0]};

  assign dx = px - xl;
  assign wx = xh - xl;
  assign dy = yh - py;
  assign wy = yh - yl;

  assign dxe = {{(NW-SB){1'b0}}, dx[SB-1:0]};
  assign dye = {{(NW-SB){1'b0}}, dy[SB-1:0]};

  always_comb begin
    lane_next.hit    = (px >= xl) && (px < xh) && (py >= yl) && (py < yh);
    lane_next.last   = point.last_point;
    lane_next.rem_x  = (dxe << xyppm_pkg::SCALE_SHIFT) - dxe;
    lane_next.rem_y  = (dye << xyppm_pkg::SCALE_SHIFT) - dye;
    lane_next.div_x  = {1'b0, wx[SB-1:0], {(xyppm_pkg::QUO_W-1){1'b0}}};
    lane_next.div_y  = {1'b0, wy[SB-1:0], {(xyppm_pkg::QUO_W-1){1'b0}}};
    lane_next.quo_x  = '0;
    lane_next.quo_y  = '0;
  end

  assign point.ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (point.ready) begin
      out_valid <= point.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (point.ready && point.valid) begin
      out_lane <= lane_next;
    end
  end
endmodule

FILE: rtl/xyppm_cell.sv
// Division cell: one quotient bit for each axis per stage.
module xyppm_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  xyppm_pkg::lane_t in_lane,
  output logic             out_valid,
  input  logic             out_ready,
  output xyppm_pkg::lane_t out_lane
);
  localparam int NW = xyppm_pkg::NUM_W;
  localparam int QW = xyppm_pkg::QUO_W;

  logic             ge_x, ge_y;
  logic [NW-1:0]    part_x, part_y;
  xyppm_pkg::lane_t lane_next;

  assign ge_x   = in_lane.rem_x >= in_lane.div_x;
  assign ge_y   = in_lane.rem_y >= in_lane.div_y;
  assign part_x = ge_x ? (in_lane.rem_x - in_lane.div_x) : in_lane.rem_x;
  assign part_y = ge_y ? (in_lane.rem_y - in_lane.div_y) : in_lane.rem_y;

  always_comb begin
    lane_next        = in_lane;
    lane_next.rem_x  = {part_x[NW-2:0], 1'b0};
    lane_next.rem_y  = {part_y[NW-2:0], 1'b0};
    lane_next.quo_x  = {in_lane.quo_x[QW-2:0], ge_x};
    lane_next.quo_y  = {in_lane.quo_y[QW-2:0], ge_y};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_lane <= lane_next;
    end
  end
endmodule

FILE: tb/xyppm_pixel_checker.sv
// Checker for the point-to-pixel mapper: predicts every pixel result and compares it.
module xyppm_pixel_checker
  import xyppm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  xyppm_point_if  point,
  xyppm_result_if result,
  xyppm_cfg_if    cfg,
  output int      mismatches,
  output int      outstanding
);

  localparam longint PIXEL_SPAN = 127;

  typedef struct packed {
    logic       hit;
    logic [6:0] column;
    logic [7:0] row;
    logic       last;
  } pixel_t;

  window_t window;
  pixel_t  pending_pixels[$];

  function automatic pixel_t map_point(window_t w, logic [FIELD_BITS-1:0] x,
                                       logic [FIELD_BITS-1:0] y, logic last);
    longint px, py, xl, xh, yl, yh, col, row;
    pixel_t p;
    px = longint'(signed'(x));
    py = longint'(signed'(y));
    xl = longint'(signed'(w.x_low));
    xh = longint'(signed'(w.x_high));
    yl = longint'(signed'(w.y_low));
    yh = longint'(signed'(w.y_high));
    col = 0;
    row = 0;
    p.hit = px >= xl && px < xh && py >= yl && py < yh;
    if (p.hit) begin
      col = (PIXEL_SPAN * (px - xl)) / (xh - xl);
      row = longint'(ROW_OFFSET) + (PIXEL_SPAN * (yh - py)) / (yh - yl);
    end
    p.column = col[6:0];
    p.row = row[7:0];
    p.last = last;
    return p;
  endfunction

  always @(posedge clk) begin : track
    pixel_t want;
    int bad;
    bad = 0;
    if (rst) begin
      window <= {RESET_X_LOW, RESET_X_HIGH, RESET_Y_LOW, RESET_Y_HIGH};
      pending_pixels.delete();
      mismatches <= 0;
      outstanding <= 0;
    end else begin
      if (result.valid && result.ready) begin
        if (pending_pixels.size() == 0) begin
          $error("result transfer with no point outstanding");
          bad++;
        end else begin
          want = pending_pixels.pop_front();
          if (result.in_window !== want.hit) begin
            $error("in_window: expected %0d, got %0d", want.hit, result.in_window);
            bad++;
          end
          if (result.pixel_column !== want.column) begin
            $error("pixel_column: expected %0d, got %0d", want.column, result.pixel_column);
            bad++;
          end
          if (result.pixel_row !== want.row) begin
            $error("pixel_row: expected %0d, got %0d", want.row, result.pixel_row);
            bad++;
          end
          if (result.last_result !== want.last) begin
            $error("last_result: expected %0d, got %0d", want.last, result.last_result);
            bad++;
          end
        end
      end
      if (point.valid && point.ready)
        pending_pixels.push_back(map_point(window, point.point_x, point.point_y,
                                           point.last_point));
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_X_LOW:  window.x_low <= cfg.data;
          REG_X_HIGH: window.x_high <= cfg.data;
          REG_Y_LOW:  window.y_low <= cfg.data;
          REG_Y_HIGH: window.y_high <= cfg.data;
          default: ;
        endcase
      end
      mismatches <= mismatches + bad;
      outstanding <= pending_pixels.size();
    end
  end

endmodule

FILE: tb/tb_xy_point_to_pixel_mapper.sv
// Testbench top for the point-to-pixel mapper: stimulus, idling and verdict.
module tb_xy_point_to_pixel_mapper;
  import xyppm_pkg::*;

  localparam longint SAMPLE_MAX = 2147483647;
  localparam longint SAMPLE_MIN = -2147483648;
  localparam logic [FIELD_BITS-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [FIELD_BITS-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [INDEX_W-1:0] REG_UNUSED = 8'hA5;
  localparam int LATENCY = 8;
  localparam int HOLD_OFF = 120;
  localparam int PHASES = 10;
  localparam int PHASE_POINTS = 65;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   outstanding;
  bit   calm;
  int   cycles;

  xyppm_point_if  point_ch();
  xyppm_result_if result_ch();
  xyppm_cfg_if    cfg_ch();

  xy_point_to_pixel_mapper dut (
    .clk(clk),
    .rst(rst),
    .point(point_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  xyppm_pixel_checker checker_i (
    .clk(clk),
    .rst(rst),
    .point(point_ch),
    .result(result_ch),
    .cfg(cfg_ch),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_point(input logic [FIELD_BITS-1:0] x, input logic [FIELD_BITS-1:0] y,
                            input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      point_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_ch.valid <= 1'b1;
    point_ch.point_x <= x;
    point_ch.point_y <= y;
    point_ch.last_point <= last;
    do @(posedge clk); while (!point_ch.ready);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [FIELD_BITS-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic write_window(input longint xl, input longint xh, input longint yl,
                              input longint yh);
    write_reg(REG_X_LOW, xl[FIELD_BITS-1:0]);
    write_reg(REG_X_HIGH, xh[FIELD_BITS-1:0]);
    write_reg(REG_Y_LOW, yl[FIELD_BITS-1:0]);
    write_reg(REG_Y_HIGH, yh[FIELD_BITS-1:0]);
  endtask

  task automatic drain();
    point_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic pick_axis(output longint lo, output longint hi);
    int word;
    longint room;
    longint unsigned r, span;
    word = $urandom;
    lo = longint'(word);
    room = SAMPLE_MAX - lo;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: begin
        word = $urandom;
        hi = longint'(word);
      end
      1: hi = lo + ((room < 300) ? room : longint'($urandom_range(1, 300)));
      2: begin
        span = room;
        hi = (room == 0) ? lo : lo + 1 + longint'(r % span);
      end
      3: begin
        lo = SAMPLE_MIN;
        word = $urandom;
        hi = $urandom_range(0, 1) ? SAMPLE_MAX : longint'(word);
      end
      default: hi = (room == 0) ? lo : lo + 1;
    endcase
  endtask

  function automatic logic [FIELD_BITS-1:0] pick_coord(longint lo, longint hi);
    longint unsigned r, span;
    longint v;
    int pick;
    r = {$urandom, $urandom};
    pick = $urandom_range(0, 19);
    if (pick < 15 && hi > lo) begin
      span = hi - lo;
      v = lo + longint'(r % span);
      return v[FIELD_BITS-1:0];
    end
    if (pick < 18) begin
      case ($urandom_range(0, 3))
        0: v = lo - 1;
        1: v = lo;
        2: v = hi - 1;
        default: v = hi;
      endcase
      return v[FIELD_BITS-1:0];
    end
    return r[FIELD_BITS-1:0];
  endfunction

  initial begin : receiver
    int gap, taken;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    result_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (taken % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (taken == 100 || taken == 400) gap = HOLD_OFF;
      if (gap != 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      taken++;
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_xy_point_to_pixel_mapper: done, errors");
    $finish;
  end

  initial begin : stimulus
    longint xl, xh, yl, yh;
    point_ch.valid <= 1'b0;
    point_ch.point_x <= '0;
    point_ch.point_y <= '0;
    point_ch.last_point <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_X_LOW;
    cfg_ch.data <= '0;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_point(0, 0, 1'b1);
    send_point(127, 127, 1'b0);
    send_point(128, 5, 1'b0);
    send_point(-1, 5, 1'b1);
    send_point(5, 128, 1'b0);
    send_point(5, -1, 1'b0);
    send_point(64, 0, 1'b0);
    send_point(WORD_MAX, WORD_MIN, 1'b1);
    send_point(WORD_MIN, WORD_MAX, 1'b0);

    drain();
    write_window(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
    cfg_ch.valid <= 1'b0;
    send_point(WORD_MIN, WORD_MIN, 1'b0);
    send_point(WORD_MAX - 1, WORD_MAX - 1, 1'b1);
    send_point(WORD_MAX, 0, 1'b0);
    send_point(0, WORD_MAX, 1'b1);
    send_point(-1, 1, 1'b0);

    drain();
    write_window(100, -100, 0, 128);
    cfg_ch.valid <= 1'b0;
    send_point(0, 5, 1'b0);
    send_point(100, 5, 1'b1);

    drain();
    write_window(7, 7, -5, -5);
    cfg_ch.valid <= 1'b0;
    send_point(7, -5, 1'b0);

    drain();
    write_window(-3, -2, 40, 41);
    write_reg(REG_UNUSED, $urandom);
    cfg_ch.valid <= 1'b0;
    send_point(-3, 40, 1'b1);
    send_point(-2, 40, 1'b0);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      pick_axis(xl, xh);
      pick_axis(yl, yh);
      write_window(xl, xh, yl, yh);
      write_reg(REG_UNUSED, $urandom);
      cfg_ch.valid <= 1'b0;
      calm = (phase % 4 == 3);
      for (int n = 0; n < PHASE_POINTS; n++)
        send_point(pick_coord(xl, xh), pick_coord(yl, yh), $urandom_range(0, 7) == 0);
    end

    drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0)
      $display("tb_xy_point_to_pixel_mapper: done, clean");
    else
      $display("tb_xy_point_to_pixel_mapper: done, errors");
    $finish;
  end

endmodule
